[rtl/msrl_pkg.sv]
// ----------------------------------------------------------------------------
// msrl_pkg
// Shared constants, codes and types of the multi-state rotating LCG generator.
// ----------------------------------------------------------------------------
package msrl_pkg;

  // Number of byte states in the row.
  localparam int NUM_STATES = 8;
  localparam int IDX_W      = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;

  // Field widths.
  localparam int BYTE_W    = 8;
  localparam int REQ_W     = 2;
  localparam int ROT_W     = 3;
  localparam int CFG_IDX_W = 2;

  // Request codes carried in the request kind field.
  localparam logic [REQ_W-1:0] REQ_GEN   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SEED  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MULT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INC  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROT  = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [BYTE_W-1:0] MULT_RST = 8'd5;
  localparam logic [BYTE_W-1:0] INC_RST  = 8'd1;
  localparam logic [ROT_W-1:0]  ROT_RST  = 3'd1;

  // Seed hashing constants: offset of the printable range and its weight.
  localparam logic [BYTE_W-1:0] SEED_OFFSET = 8'd32;
  localparam logic [BYTE_W-1:0] SEED_WEIGHT = 8'd3;
  localparam logic [BYTE_W-1:0] SEED_MAX    = 8'hFF;

  // Write and clear request from the sequencer to the state bank.
  typedef struct packed {
    logic              clr;
    logic              we;
    logic [IDX_W-1:0]  addr;
    logic [BYTE_W-1:0] data;
  } bank_wr_t;

endpackage

[rtl/msrl_bank.sv]
// ----------------------------------------------------------------------------
// msrl_bank
// Row of byte states with per-entry valid bits; a cleared entry reads as zero.
// ----------------------------------------------------------------------------
module msrl_bank (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  msrl_pkg::bank_wr_t             wr_i,
  input  logic [msrl_pkg::IDX_W-1:0]     raddr_i,
  output logic [msrl_pkg::BYTE_W-1:0]    rdata_o
);

  logic [msrl_pkg::BYTE_W-1:0]     mem_q [msrl_pkg::NUM_STATES];
  logic [msrl_pkg::NUM_STATES-1:0] valid_q;

  // Valid bits: a clear drops them all at once, a write sets one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_i.clr) begin
      valid_q <= '0;
    end else if (wr_i.we) begin
      valid_q[wr_i.addr] <= 1'b1;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (wr_i.we && !wr_i.clr) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  assign rdata_o = valid_q[raddr_i] ? mem_q[raddr_i] : '0;

endmodule

[rtl/msrl_mac.sv]
// ----------------------------------------------------------------------------
// msrl_mac
// Shared byte multiply-add unit: y = (a * b + c) mod 256, registered.
// ----------------------------------------------------------------------------
module msrl_mac (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [msrl_pkg::BYTE_W-1:0] a_i,
  input  logic [msrl_pkg::BYTE_W-1:0] b_i,
  input  logic [msrl_pkg::BYTE_W-1:0] c_i,
  output logic [msrl_pkg::BYTE_W-1:0] y_o
);

  logic [2*msrl_pkg::BYTE_W-1:0] prod;
  logic [msrl_pkg::BYTE_W-1:0]   y_d;
  logic [msrl_pkg::BYTE_W-1:0]   y_q;

  // Only the low byte of the product matters.
  assign prod = a_i * b_i;
  assign y_d  = prod[msrl_pkg::BYTE_W-1:0] + c_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      y_q <= y_d;
    end
  end

  assign y_o = y_q;

endmodule

[rtl/multi_state_rotate_lcg_prng.sv]
// ----------------------------------------------------------------------------
// multi_state_rotate_lcg_prng
// Byte generator over a row of rotating LCG states, with string seeding.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake             | Payload
//  ---------+-----------+-----------------------+------------------------------
//  s_*      | in        | s_tvalid_i/s_tready_o | tdata: seed_char; tuser: kind
//  m_*      | out       | m_tvalid_o/m_tready_i | tdata: value
//  cfg_*    | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One request is worked at a time by a sequencer around one shared multiply-add.
// Generate walks 1 to NUM_STATES states by GEN_MUL, GEN_ACC; all end in DONE.
// Seed: MIX_MUL, MIX_WR for a first character, HASH_MUL, HASH_WR if hashed.
// The output register holds a finished result, so one more request can be taken
// while it waits; that request then stalls in DONE until the result
// is taken. Reset clears states, sums and handshakes; config is always ready.
module multi_state_rotate_lcg_prng (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Request stream.
  input  logic                               s_tvalid_i,
  output logic                               s_tready_o,
  input  logic [7:0]                         s_tdata_i,   // [7:0] seed_char
  input  logic [2:0]                         s_tuser_i,   // [1:0] req_type, [2] seed_first
  // Result stream.
  output logic                               m_tvalid_o,
  input  logic                               m_tready_i,
  output logic [7:0]                         m_tdata_o,   // [7:0] value
  // Configuration writes.
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [msrl_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [msrl_pkg::BYTE_W-1:0]        cfg_data_i
);

  localparam int ST_W = 3;
  localparam logic [ST_W-1:0] ST_IDLE     = 3'd0;
  localparam logic [ST_W-1:0] ST_GEN_MUL  = 3'd1;
  localparam logic [ST_W-1:0] ST_GEN_ACC  = 3'd2;
  localparam logic [ST_W-1:0] ST_MIX_MUL  = 3'd3;
  localparam logic [ST_W-1:0] ST_MIX_WR   = 3'd4;
  localparam logic [ST_W-1:0] ST_HASH_MUL = 3'd5;
  localparam logic [ST_W-1:0] ST_HASH_WR  = 3'd6;
  localparam logic [ST_W-1:0] ST_DONE     = 3'd7;

  localparam logic [msrl_pkg::IDX_W-1:0] IDX_LAST =
    msrl_pkg::IDX_W'(msrl_pkg::NUM_STATES - 1);

  logic [ST_W-1:0]                 state_q, state_d;
  logic [msrl_pkg::BYTE_W-1:0]     mult_q, inc_q;
  logic [msrl_pkg::ROT_W-1:0]      rot_q;
  logic [msrl_pkg::BYTE_W-1:0]     char_q, char_d;
  logic [msrl_pkg::BYTE_W-1:0]     mix_q, mix_d;
  logic [msrl_pkg::BYTE_W-1:0]     seed_sum_q, seed_sum_d;
  logic [msrl_pkg::BYTE_W-1:0]     seed_cnt_q, seed_cnt_d;
  logic [msrl_pkg::IDX_W-1:0]      seed_idx_q, seed_idx_d;
  logic                            seed_open_q, seed_open_d;
  logic [msrl_pkg::IDX_W-1:0]      gen_idx_q, gen_idx_d;
  logic                            out_valid_q, out_valid_d;
  logic [msrl_pkg::BYTE_W-1:0]     out_data_q, out_data_d;

  logic                            in_fire;
  logic [msrl_pkg::REQ_W-1:0]      in_req;
  logic                            in_first;
  msrl_pkg::bank_wr_t              bank_wr;
  logic [msrl_pkg::BYTE_W-1:0]     bank_rd;
  logic [2*msrl_pkg::BYTE_W-1:0]   rot_wide;
  logic [msrl_pkg::BYTE_W-1:0]     rot_val;
  logic                            mac_en;
  logic [msrl_pkg::BYTE_W-1:0]     mac_a, mac_b, mac_c, mac_y;

  assign in_req     = s_tuser_i[1:0];
  assign in_first   = s_tuser_i[2];
  assign s_tready_o = (state_q == ST_IDLE);
  assign in_fire    = s_tvalid_i && s_tready_o;
  assign cfg_ready_o = 1'b1;
  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;

  // Right rotation of the addressed state.
  assign rot_wide = {bank_rd, bank_rd} >> rot_q;
  assign rot_val  = rot_wide[msrl_pkg::BYTE_W-1:0];

  msrl_bank u_bank (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (bank_wr),
    .raddr_i (gen_idx_q),
    .rdata_o (bank_rd)
  );

  msrl_mac u_mac (
    .clk_i (clk_i),
    .en_i  (mac_en),
    .a_i   (mac_a),
    .b_i   (mac_b),
    .c_i   (mac_c),
    .y_o   (mac_y)
  );

  // Operand selection for the shared multiply-add.
  always_comb begin
    mac_en = 1'b0;
    mac_a  = rot_val;
    mac_b  = mult_q;
    mac_c  = inc_q;
    case (state_q)
      ST_GEN_MUL: begin
        mac_en = 1'b1;
      end
      ST_MIX_MUL: begin
        mac_en = 1'b1;
        mac_a  = char_q;
      end
      ST_HASH_MUL: begin
        mac_en = 1'b1;
        mac_a  = char_q - msrl_pkg::SEED_OFFSET;
        mac_b  = msrl_pkg::SEED_WEIGHT;
        mac_c  = seed_sum_q;
      end
      default: begin
        mac_en = 1'b0;
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    char_d      = char_q;
    mix_d       = mix_q;
    seed_sum_d  = seed_sum_q;
    seed_cnt_d  = seed_cnt_q;
    seed_idx_d  = seed_idx_q;
    seed_open_d = seed_open_q;
    gen_idx_d   = gen_idx_q;
    out_valid_d = out_valid_q && !m_tready_i;
    out_data_d  = out_data_q;
    bank_wr     = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          char_d  = s_tdata_i;
          case (in_req)
            msrl_pkg::REQ_GEN: begin
              gen_idx_d = '0;
              state_d   = ST_GEN_MUL;
            end
            msrl_pkg::REQ_SEED: begin
              if (in_first) begin
                bank_wr.clr = 1'b1;
                seed_sum_d  = '0;
                seed_cnt_d  = '0;
                seed_idx_d  = '0;
                seed_open_d = (s_tdata_i != '0);
                state_d     = ST_MIX_MUL;
              end else if (seed_open_q) begin
                if (s_tdata_i == '0) begin
                  seed_open_d = 1'b0;
                  state_d     = ST_DONE;
                end else begin
                  state_d = ST_HASH_MUL;
                end
              end else begin
                state_d = ST_DONE;
              end
            end
            msrl_pkg::REQ_CLEAR: begin
              bank_wr.clr = 1'b1;
              seed_open_d = 1'b0;
              state_d     = ST_DONE;
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_GEN_MUL: begin
        state_d = ST_GEN_ACC;
      end
      // Store the new state, fold it into the running byte, decide on exit.
      ST_GEN_ACC: begin
        bank_wr.we   = 1'b1;
        bank_wr.addr = gen_idx_q;
        bank_wr.data = mac_y;
        mix_d        = mix_q + mac_y;
        if ((mac_y == '0) || (mac_y[4:0] != '0) || (gen_idx_q == IDX_LAST)) begin
          state_d = ST_DONE;
        end else begin
          gen_idx_d = gen_idx_q + 1'b1;
          state_d   = ST_GEN_MUL;
        end
      end
      ST_MIX_MUL: begin
        state_d = ST_MIX_WR;
      end
      ST_MIX_WR: begin
        mix_d   = mac_y;
        state_d = seed_open_q ? ST_HASH_MUL : ST_DONE;
      end
      ST_HASH_MUL: begin
        state_d = ST_HASH_WR;
      end
      // Hash step: new sum goes to the next state slot in turn.
      ST_HASH_WR: begin
        seed_sum_d   = mac_y;
        bank_wr.we   = 1'b1;
        bank_wr.addr = seed_idx_q;
        bank_wr.data = mac_y;
        seed_cnt_d   = seed_cnt_q + 1'b1;
        seed_idx_d   = (seed_idx_q == IDX_LAST) ? '0 : seed_idx_q + 1'b1;
        if (seed_cnt_d == msrl_pkg::SEED_MAX) begin
          seed_open_d = 1'b0;
        end
        state_d = ST_DONE;
      end
      // Hand the running byte to the output register once it is free.
      ST_DONE: begin
        if (!out_valid_q || m_tready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = mix_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control and running state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mix_q       <= '0;
      seed_sum_q  <= '0;
      seed_cnt_q  <= '0;
      seed_idx_q  <= '0;
      seed_open_q <= 1'b0;
      gen_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mix_q       <= mix_d;
      seed_sum_q  <= seed_sum_d;
      seed_cnt_q  <= seed_cnt_d;
      seed_idx_q  <= seed_idx_d;
      seed_open_q <= seed_open_d;
      gen_idx_q   <= gen_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    char_q     <= char_d;
    out_data_q <= out_data_d;
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mult_q <= msrl_pkg::MULT_RST;
      inc_q  <= msrl_pkg::INC_RST;
      rot_q  <= msrl_pkg::ROT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        msrl_pkg::CFG_MULT: mult_q <= cfg_data_i;
        msrl_pkg::CFG_INC:  inc_q  <= cfg_data_i;
        msrl_pkg::CFG_ROT:  rot_q  <= cfg_data_i[msrl_pkg::ROT_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

[rtl/msrl_checker.sv]
// ----------------------------------------------------------------------------
// msrl_checker
// Port-level checks of the generator: request bookkeeping and output holding.
// ----------------------------------------------------------------------------
module msrl_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_tvalid_i,
  input logic       s_tready_o,
  input logic       m_tvalid_o,
  input logic       m_tready_i,
  input logic [7:0] m_tdata_o
);

  logic [1:0] pend_q;
  logic       in_fire;
  logic       out_fire;

  assign in_fire  = s_tvalid_i && s_tready_o;
  assign out_fire = m_tvalid_o && m_tready_i;

  // Requests taken whose result is not yet delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + {1'b0, in_fire} - {1'b0, out_fire};
    end
  end

  // A result is only shown for a request that was taken.
  a_out_has_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> (pend_q != 2'd0))
    else $error("result shown without an outstanding request");

  // At most one request in work and one result waiting.
  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("more than two requests outstanding");

  // The input side is busy only while a request is in work.
  a_busy_has_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_tready_o |-> (pend_q != 2'd0))
    else $error("input stalled with nothing outstanding");

  // A waiting result holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && !m_tready_i) |=> (m_tvalid_o && $stable(m_tdata_o)))
    else $error("waiting result changed or dropped");

endmodule

bind multi_state_rotate_lcg_prng msrl_checker u_msrl_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_tvalid_i),
  .s_tready_o (s_tready_o),
  .m_tvalid_o (m_tvalid_o),
  .m_tready_i (m_tready_i),
  .m_tdata_o  (m_tdata_o)
);

[sim/msrl_value_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msrl_value_checker
// Watches the request, result and configuration channels of the rotating LCG
// generator, predicts the running byte that each accepted request returns and
// compares every accepted result with the oldest predicted byte.
// ----------------------------------------------------------------------------
module msrl_value_checker
  import msrl_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_tvalid_i,
  input  logic                 s_tready_i,
  input  logic [7:0]           s_tdata_i,   // [7:0] seed_char
  input  logic [2:0]           s_tuser_i,   // [1:0] req_type, [2] seed_first
  input  logic                 m_tvalid_i,
  input  logic                 m_tready_i,
  input  logic [7:0]           m_tdata_i,   // [7:0] value
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [BYTE_W-1:0]    cfg_data_i,
  output int                   error_count_o,
  output int                   pending_o
);

  // Shadow copy of the generator state and its configuration.
  logic [7:0] lcg_state [NUM_STATES];
  logic [7:0] mix_acc;
  logic [7:0] seed_acc;
  logic [7:0] seed_cnt;
  logic       seed_active;
  logic [7:0] mult_q;
  logic [7:0] inc_q;
  logic [2:0] rot_q;

  // Running bytes still owed by the block, oldest first.
  logic [7:0] owed_values [$];
  int         errors = 0;

  function automatic logic [7:0] rotate_right_byte(input logic [7:0] v, input logic [2:0] r);
    logic [15:0] twice;
    twice = {v, v} >> r;
    return twice[7:0];
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t ns: ERROR: %s", $time, what);
    errors++;
  endtask

  task automatic clear_lcg_state();
    for (int i = 0; i < NUM_STATES; i++) lcg_state[i] = '0;
  endtask

  // One seed character folded into the hash and stored in the next state slot.
  task automatic hash_seed_char(input logic [7:0] ch);
    seed_acc = seed_acc + (ch - 8'd32) * 8'd3;
    lcg_state[seed_cnt % NUM_STATES] = seed_acc;
    seed_cnt = seed_cnt + 8'd1;
    if (seed_cnt == 8'hFF) seed_active = 1'b0;
  endtask

  // Walk the states until one lands on zero or has nonzero low five bits.
  task automatic walk_states();
    logic [7:0] s;
    bit         stop;
    stop = 1'b0;
    for (int i = 0; i < NUM_STATES && !stop; i++) begin
      s = rotate_right_byte(lcg_state[i], rot_q) * mult_q + inc_q;
      lcg_state[i] = s;
      mix_acc = mix_acc + s;
      if (s == 8'd0 || s[4:0] != 5'd0) stop = 1'b1;
    end
  endtask

  task automatic apply_request(input logic [1:0] kind, input logic [7:0] ch, input logic first);
    case (kind)
      REQ_GEN: begin
        walk_states();
      end
      REQ_SEED: begin
        if (first) begin
          clear_lcg_state();
          mix_acc     = ch * mult_q + inc_q;
          seed_acc    = '0;
          seed_cnt    = '0;
          seed_active = (ch != 8'd0);
          if (seed_active) hash_seed_char(ch);
        end else if (seed_active) begin
          if (ch == 8'd0) seed_active = 1'b0;
          else hash_seed_char(ch);
        end
      end
      REQ_CLEAR: begin
        clear_lcg_state();
        seed_active = 1'b0;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic [7:0] want;
    if (!rst_ni) begin
      clear_lcg_state();
      mix_acc     = '0;
      seed_acc    = '0;
      seed_cnt    = '0;
      seed_active = 1'b0;
      mult_q      = MULT_RST;
      inc_q       = INC_RST;
      rot_q       = ROT_RST;
      owed_values.delete();
      error_count_o <= errors;
      pending_o     <= 0;
    end else begin
      // Register writes land first; they only come while the block is idle.
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_MULT: mult_q = cfg_data_i;
          CFG_INC:  inc_q  = cfg_data_i;
          CFG_ROT:  rot_q  = cfg_data_i[2:0];
          default: ;
        endcase
      end

      // Every accepted request owes exactly one running byte.
      if (s_tvalid_i && s_tready_i) begin
        apply_request(s_tuser_i[1:0], s_tdata_i, s_tuser_i[2]);
        owed_values.push_back(mix_acc);
      end

      // Compare the delivered byte with the oldest one owed.
      if (m_tvalid_i && m_tready_i) begin
        if (owed_values.size() == 0) begin
          report_mismatch($sformatf("result %02h with no request outstanding", m_tdata_i));
        end else begin
          want = owed_values.pop_front();
          if (m_tdata_i !== want)
            report_mismatch($sformatf("value %02h, expected %02h", m_tdata_i, want));
        end
      end

      error_count_o <= errors;
      pending_o     <= owed_values.size();
    end
  end

endmodule

[sim/multi_state_rotate_lcg_prng_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_state_rotate_lcg_prng_test
// Drives requests and register writes into the rotating LCG generator under
// several pacing modes and settings; a checker beside the block predicts and
// compares every returned byte, and this module gives the verdict.
// ----------------------------------------------------------------------------
module multi_state_rotate_lcg_prng_test;
  import msrl_pkg::*;

  localparam real CLK_PERIOD     = 8.0;
  localparam int  RESET_CYCLES   = 11;
  localparam int  RANDOM_ITEMS   = 950;
  localparam int  SEGMENTS       = 8;
  localparam int  HOLD_CYCLES    = 300;
  localparam int  WATCHDOG_LIMIT = 4000;
  localparam int  DRAIN_CYCLES   = 40;

  // Request code that the block treats as a no-op.
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic [7:0] mult;
    logic [7:0] inc;
    logic [2:0] rot;
  } gen_cfg_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 s_tvalid    = 1'b0;
  logic                 s_tready;
  logic [7:0]           s_tdata     = '0;
  logic [2:0]           s_tuser     = '0;
  logic                 m_tvalid;
  logic                 m_tready    = 1'b0;
  logic [7:0]           m_tdata;
  logic                 cfg_valid   = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index   = '0;
  logic [BYTE_W-1:0]    cfg_data    = '0;

  int   errors_seen;
  int   owed_count;
  int   src_idle_pct  = 0;
  int   snk_stall_pct = 0;
  logic hold_req      = 1'b0;
  int   hold_count    = 0;
  int   quiet_cycles  = 0;
  int   live_items    = 0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  multi_state_rotate_lcg_prng dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_tvalid),
    .s_tready_o  (s_tready),
    .s_tdata_i   (s_tdata),
    .s_tuser_i   (s_tuser),
    .m_tvalid_o  (m_tvalid),
    .m_tready_i  (m_tready),
    .m_tdata_o   (m_tdata),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  msrl_value_checker value_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_tvalid_i    (s_tvalid),
    .s_tready_i    (s_tready),
    .s_tdata_i     (s_tdata),
    .s_tuser_i     (s_tuser),
    .m_tvalid_i    (m_tvalid),
    .m_tready_i    (m_tready),
    .m_tdata_i     (m_tdata),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .error_count_o (errors_seen),
    .pending_o     (owed_count)
  );

  // Result side: random stalls, plus one long hold-off while hold_req is up.
  always @(posedge clk_i) begin
    if (hold_req && hold_count < HOLD_CYCLES) begin
      m_tready   <= 1'b0;
      hold_count <= hold_count + 1;
    end else begin
      m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // Watchdog: ends the run when no channel moves for too long.
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: watchdog expired, no request moved for %0d cycles", $time,
               WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Offer one request, idling beforehand as the sender pacing asks.
  task automatic offer_request(input logic [1:0] kind, input logic [7:0] ch, input logic first);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= ch;
    s_tuser  <= {first, kind};
    do @(posedge clk_i); while (!s_tready);
    if (kind != REQ_UNUSED) live_items++;
  endtask

  // Stop offering and wait until every owed byte has come back.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (owed_count != 0) @(posedge clk_i);
  endtask

  // Write all three registers back to back; only called while idle.
  task automatic load_config(input gen_cfg_t c);
    logic [CFG_IDX_W-1:0] idx [3];
    logic [BYTE_W-1:0]    val [3];
    idx[0] = CFG_MULT;
    idx[1] = CFG_INC;
    idx[2] = CFG_ROT;
    val[0] = c.mult;
    val[1] = c.inc;
    val[2] = {5'd0, c.rot};
    for (int k = 0; k < 3; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      do @(posedge clk_i); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] seed_letter();
    return $urandom_range(1) ? 8'($urandom_range(32, 126)) : 8'($urandom_range(1, 255));
  endfunction

  task automatic offer_generate();
    offer_request(REQ_GEN, 8'($urandom), 1'($urandom_range(1)));
  endtask

  // One random stretch: mostly whole seed strings followed by generates.
  task automatic random_burst();
    int pick;
    int len;
    pick = $urandom_range(99);
    if (pick < 55) begin
      len = ($urandom_range(7) == 0) ? $urandom_range(12, 40) : $urandom_range(0, 9);
      if (len == 0) begin
        offer_request(REQ_SEED, 8'h00, 1'b1);
      end else begin
        offer_request(REQ_SEED, seed_letter(), 1'b1);
        for (int k = 1; k < len; k++) begin
          if ($urandom_range(9) == 0) offer_generate();
          offer_request(REQ_SEED, seed_letter(), 1'b0);
        end
        if ($urandom_range(5) != 0) offer_request(REQ_SEED, 8'h00, 1'b0);
      end
      repeat ($urandom_range(1, 6)) offer_generate();
    end else if (pick < 80) begin
      repeat ($urandom_range(1, 8)) offer_generate();
    end else if (pick < 88) begin
      offer_request(REQ_CLEAR, 8'($urandom), 1'($urandom_range(1)));
      repeat ($urandom_range(0, 3)) offer_generate();
    end else begin
      // Noise: any code, any character, any first flag.
      repeat ($urandom_range(1, 4))
        offer_request(2'($urandom_range(3)), 8'($urandom), 1'($urandom_range(1)));
    end
  endtask

  initial begin
    gen_cfg_t seg_cfg   [SEGMENTS];
    int       idle_tab  [4];
    int       stall_tab [4];
    int       target;

    idle_tab  = '{0, 80, 0, 10};
    stall_tab = '{0, 0, 80, 10};
    seg_cfg[0] = '{mult: 8'd0,   inc: 8'd0,   rot: 3'd0};
    seg_cfg[1] = '{mult: 8'd255, inc: 8'd255, rot: 3'd7};
    seg_cfg[2] = '{mult: 8'd0,   inc: 8'd32,  rot: 3'd3};
    seg_cfg[3] = '{mult: MULT_RST, inc: INC_RST, rot: ROT_RST};
    seg_cfg[4] = '{mult: 8'd64,  inc: 8'd96,  rot: 3'd0};
    seg_cfg[5] = '{mult: 8'($urandom), inc: 8'($urandom), rot: 3'($urandom_range(7))};
    seg_cfg[6] = '{mult: 8'd32,  inc: 8'd224, rot: 3'd5};
    seg_cfg[7] = '{mult: {3'($urandom), 5'd0}, inc: {3'($urandom), 5'd0},
                   rot: 3'($urandom_range(7))};

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed pass at the reset settings.
    offer_request(REQ_GEN, 8'h00, 1'b0);          // all states zero
    offer_request(REQ_GEN, 8'hFF, 1'b1);
    offer_request(REQ_SEED, 8'h41, 1'b1);         // new string
    offer_request(REQ_SEED, 8'h20, 1'b0);         // space adds zero to the hash
    offer_request(REQ_SEED, 8'hFF, 1'b0);
    offer_request(REQ_SEED, 8'h01, 1'b0);
    offer_request(REQ_GEN, 8'h00, 1'b0);          // generate inside an open string
    offer_request(REQ_SEED, 8'h7E, 1'b0);
    offer_request(REQ_SEED, 8'h00, 1'b0);         // terminator
    offer_request(REQ_SEED, 8'h55, 1'b0);         // no open string: ignored
    offer_request(REQ_GEN, 8'h00, 1'b0);
    offer_request(REQ_GEN, 8'h00, 1'b0);
    offer_request(REQ_SEED, 8'h00, 1'b1);         // empty string
    offer_request(REQ_SEED, 8'h33, 1'b0);         // ignored after an empty string
    offer_request(REQ_CLEAR, 8'hAA, 1'b1);
    offer_request(REQ_UNUSED, 8'hAA, 1'b1);
    offer_request(REQ_GEN, 8'h00, 1'b0);
    offer_request(REQ_SEED, 8'hFF, 1'b1);
    offer_request(REQ_SEED, 8'h80, 1'b0);
    offer_request(REQ_CLEAR, 8'h00, 1'b0);        // clear while a string is open
    offer_request(REQ_SEED, 8'h10, 1'b0);         // ignored after the clear
    offer_request(REQ_GEN, 8'h00, 1'b0);
    offer_request(REQ_SEED, 8'h1F, 1'b1);
    offer_request(REQ_UNUSED, 8'h00, 1'b0);
    offer_request(REQ_GEN, 8'h00, 1'b0);

    // A string longer than the hash accepts closes itself after 255 characters.
    offer_request(REQ_SEED, 8'h61, 1'b1);
    repeat (260) offer_request(REQ_SEED, 8'($urandom_range(1, 255)), 1'b0);
    repeat (4) offer_generate();
    offer_request(REQ_SEED, 8'h00, 1'b0);
    repeat (3) offer_generate();
    wait_drained();

    // Long hold-off on the result side while requests keep coming.
    hold_req <= 1'b1;
    repeat (6) begin
      offer_request(REQ_SEED, seed_letter(), 1'b1);
      offer_generate();
    end
    wait_drained();
    hold_req <= 1'b0;

    // Random segments across pacing modes and register settings.
    for (int p = 0; p < SEGMENTS; p++) begin
      wait_drained();
      src_idle_pct  = idle_tab[p / 2];
      snk_stall_pct <= stall_tab[p / 2];
      load_config(seg_cfg[p]);
      target = live_items + RANDOM_ITEMS / SEGMENTS;
      while (live_items < target) random_burst();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors_seen == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[sim.f]
rtl/msrl_pkg.sv
rtl/msrl_bank.sv
rtl/msrl_mac.sv
rtl/multi_state_rotate_lcg_prng.sv
rtl/msrl_checker.sv
sim/msrl_value_checker.sv
sim/multi_state_rotate_lcg_prng_test.sv
